// File: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and helpers of the base64 packet deframer.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int LENGTH_BYTES = 2;
  localparam int SUM_BYTES    = 4;
  localparam int GROUP_DEPTH  = 4;

  localparam logic [31:0] SUM_MASK = 32'((64'd1 << (8 * SUM_BYTES)) - 64'd1);

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_GOOD   = 2'd1;
  localparam logic [1:0] KIND_SUMERR = 2'd2;
  localparam logic [1:0] KIND_ABORT  = 2'd3;

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_HDR_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_PAY = 2'd2;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  typedef struct packed {
    logic [63:0] header_pattern;
    logic [3:0]  header_length;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } group_t;

  typedef struct packed {
    logic       valid;
    logic       pad;
    logic [5:0] value;
  } b64_t;

  function automatic b64_t b64_decode(logic [7:0] c);
    b64_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.valid = 1'b1;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.valid = 1'b1;
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.valid = 1'b1;
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.valid = 1'b1;
      r.value = 6'd63;
    end else if (c == 8'h3D) begin
      r.valid = 1'b1;
      r.pad   = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/b64d_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready stream interfaces for raw characters and deframer results.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink (input valid, input kind, input data, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/b64d_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_cfg
// APB register bank: header pattern, header length and maximum body length.
// ----------------------------------------------------------------------------
module b64d_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output b64d_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_pattern <= '0;
      cfg.header_length  <= 4'd1;
      cfg.max_payload    <= 16'hFFFF;
    end else if (wr_en) begin
      case (reg_idx)
        b64d_pkg::REG_PATTERN: cfg.header_pattern <= pwdata;
        b64d_pkg::REG_HDR_LEN: cfg.header_length  <= pwdata[3:0];
        b64d_pkg::REG_MAX_PAY: cfg.max_payload    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      b64d_pkg::REG_PATTERN: prdata = cfg.header_pattern;
      b64d_pkg::REG_HDR_LEN: prdata = {60'd0, cfg.header_length};
      b64d_pkg::REG_MAX_PAY: prdata = {48'd0, cfg.max_payload};
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/b64d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_core
// Input register and single-pass framing logic: header hunt, base64 quanta,
// length, body, checksum. Emits a group of up to three results per character.
// ----------------------------------------------------------------------------
module b64d_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64d_pkg::cfg_t  cfg,
  input  wire logic            room,
  b64d_in_if.sink              in_ch,
  output logic                 push,
  output b64d_pkg::group_t     push_group
);

  typedef enum logic [1:0] {MODE_HUNT, MODE_LEN, MODE_BODY, MODE_SUM} mode_t;

  logic        held_valid;
  logic [7:0]  held_byte;

  mode_t       mode, mode_next;
  logic [2:0]  step_count, step_next;
  logic [5:0]  qchars [3];
  logic [5:0]  qchars_next [3];
  logic [1:0]  qfill, qfill_next;
  logic        pad_third, pad_next;
  logic [15:0] length_value, length_next;
  logic        len_over, over_next;
  logic [15:0] body_count, body_next;
  logic [31:0] running_sum, rsum_next;
  logic [31:0] received_sum, xsum_next;
  logic        skip, skip_next;

  b64d_pkg::group_t grp;
  b64d_pkg::b64_t   bval;
  logic [3:0]  hl;
  logic [7:0]  expect_char;
  logic        is_space;
  logic [23:0] word;
  logic [1:0]  nbytes;
  logic [1:0]  n;
  logic [7:0]  b;

  assign in_ch.ready = room;
  assign push        = held_valid && (grp.count != 2'd0);
  assign push_group  = grp;

  assign bval        = b64d_pkg::b64_decode(held_byte);
  assign expect_char = cfg.header_pattern[{step_count, 3'b000} +: 8];
  assign is_space    = (held_byte == b64d_pkg::CHAR_LF) || (held_byte == b64d_pkg::CHAR_CR) ||
                       (held_byte == b64d_pkg::CHAR_SP) || (held_byte == b64d_pkg::CHAR_TAB);

  always_comb begin
    if (cfg.header_length == 4'd0) begin
      hl = 4'd1;
    end else if (cfg.header_length > 4'd8) begin
      hl = 4'd8;
    end else begin
      hl = cfg.header_length;
    end
  end

  always_comb begin
    mode_next    = mode;
    step_next    = step_count;
    qchars_next  = qchars;
    qfill_next   = qfill;
    pad_next     = pad_third;
    length_next  = length_value;
    over_next    = len_over;
    body_next    = body_count;
    rsum_next    = running_sum;
    xsum_next    = received_sum;
    skip_next    = skip;
    grp          = '0;
    n            = 2'd0;
    word         = {qchars[0], qchars[1], qchars[2], bval.value};
    nbytes       = pad_third ? 2'd1 : (bval.pad ? 2'd2 : 2'd3);
    b            = '0;
    if (held_valid) begin
      if (skip) begin
        if (held_byte == b64d_pkg::CHAR_LF) begin
          skip_next = 1'b0;
        end
      end else if (mode == MODE_HUNT) begin
        if (held_byte != expect_char) begin
          step_next = 3'd0;
        end else if ({1'b0, step_count} + 4'd1 >= hl) begin
          mode_next   = MODE_LEN;
          step_next   = 3'd0;
          qfill_next  = 2'd0;
          pad_next    = 1'b0;
          length_next = '0;
          over_next   = 1'b0;
        end else begin
          step_next = step_count + 3'd1;
        end
      end else if (!bval.valid) begin
        if (!is_space) begin
          grp.res[n].kind = b64d_pkg::KIND_ABORT;
          n               = n + 2'd1;
          mode_next       = MODE_HUNT;
          step_next       = 3'd0;
        end
      end else if (qfill != 2'd3) begin
        qchars_next[qfill] = bval.value;
        if (qfill == 2'd2) begin
          pad_next = bval.pad;
        end
        qfill_next = qfill + 2'd1;
      end else begin
        qfill_next = 2'd0;
        pad_next   = 1'b0;
        for (int i = 0; i < 3; i++) begin
          b = word[23 - 8 * i -: 8];
          if (2'(i) < nbytes && mode_next != MODE_HUNT) begin
            case (mode_next)
              MODE_LEN: begin
                if (length_next[15:8] != 8'd0) begin
                  over_next = 1'b1;
                end
                length_next = {length_next[7:0], b};
                step_next   = step_next + 3'd1;
                if (step_next >= 3'(b64d_pkg::LENGTH_BYTES)) begin
                  step_next = 3'd0;
                  if (over_next || length_next > cfg.max_payload) begin
                    grp.res[n].kind = b64d_pkg::KIND_ABORT;
                    n               = n + 2'd1;
                    mode_next       = MODE_HUNT;
                  end else begin
                    rsum_next = '0;
                    body_next = '0;
                    xsum_next = '0;
                    mode_next = (length_next == 16'd0) ? MODE_SUM : MODE_BODY;
                  end
                end
              end
              MODE_BODY: begin
                grp.res[n].kind = b64d_pkg::KIND_BODY;
                grp.res[n].data = b;
                n               = n + 2'd1;
                rsum_next       = rsum_next + 32'(b);
                body_next       = body_next + 16'd1;
                if (body_next == length_next) begin
                  mode_next = MODE_SUM;
                  step_next = 3'd0;
                  xsum_next = '0;
                end
              end
              MODE_SUM: begin
                xsum_next = {xsum_next[23:0], b};
                step_next = step_next + 3'd1;
                if (step_next >= 3'(b64d_pkg::SUM_BYTES)) begin
                  mode_next = MODE_HUNT;
                  step_next = 3'd0;
                  if ((xsum_next & b64d_pkg::SUM_MASK) ==
                      (rsum_next & b64d_pkg::SUM_MASK)) begin
                    grp.res[n].kind = b64d_pkg::KIND_GOOD;
                    skip_next       = 1'b1;
                  end else begin
                    grp.res[n].kind = b64d_pkg::KIND_SUMERR;
                  end
                  n = n + 2'd1;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      held_byte <= in_ch.in_byte;
    end
    qchars <= qchars_next;
    if (rst) begin
      held_valid   <= 1'b0;
      mode         <= MODE_HUNT;
      step_count   <= 3'd0;
      qfill        <= 2'd0;
      pad_third    <= 1'b0;
      len_over     <= 1'b0;
      skip         <= 1'b0;
      length_value <= '0;
      body_count   <= '0;
      running_sum  <= '0;
      received_sum <= '0;
    end else begin
      held_valid   <= in_ch.valid && in_ch.ready;
      mode         <= mode_next;
      step_count   <= step_next;
      qfill        <= qfill_next;
      pad_third    <= pad_next;
      len_over     <= over_next;
      skip         <= skip_next;
      length_value <= length_next;
      body_count   <= body_next;
      running_sum  <= rsum_next;
      received_sum <= xsum_next;
    end
  end

`ifndef ASSERT_OFF
  a_skip_in_hunt: assert property (@(posedge clk) disable iff (rst)
    skip |-> mode == MODE_HUNT)
    else $error("newline skip active outside header hunt");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_HUNT |-> step_count < 3'd4)
    else $error("length or checksum byte count out of range");

  a_body_bounded: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_BODY |-> body_count < length_value)
    else $error("body count reached length without leaving body");
`endif

endmodule
`default_nettype wire

// File: rtl/b64d_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_fifo
// Result group queue; unpacks each group into one output transaction per result.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int DEPTH = b64d_pkg::GROUP_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b64d_pkg::group_t  push_group,
  output logic                   room,
  b64d_out_if.source             out_ch
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  b64d_pkg::group_t mem [DEPTH];
  b64d_pkg::group_t head;
  b64d_pkg::result_t cur;

  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic [1:0]      idx;
  logic            xfer;
  logic            pop;

  assign head         = mem[rd_ptr];
  assign cur          = head.res[idx];
  assign out_ch.valid = count != '0;
  assign out_ch.kind  = cur.kind;
  assign out_ch.data  = cur.data;
  assign out_ch.last  = idx == (head.count - 2'd1);
  assign xfer         = out_ch.valid && out_ch.ready;
  assign pop          = xfer && out_ch.last;
  assign room         = count <= CntW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
      if (xfer) begin
        idx <= out_ch.last ? 2'd0 : idx + 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && count == CntW'(DEPTH) |-> pop)
    else $error("result group pushed into a full queue");

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> idx < head.count)
    else $error("result index beyond head group");

  a_no_empty_group: assert property (@(posedge clk) disable iff (rst)
    push |-> push_group.count != 2'd0)
    else $error("empty result group queued");
`endif

endmodule
`default_nettype wire

// File: rtl/base64_packet_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a character accepted on in_ch is held in the core's input register, and its
//   results are written into the result queue before they are offered on out_ch.
// Throughput: one character per cycle; in_ch.ready drops while more than DEPTH-2
//   result groups are queued, each group giving one to three output transactions.
// Reset: synchronous rst returns to header hunt, empties the result queue and
//   loads the register defaults (pattern 0, header length 1, max body 65535).
// ----------------------------------------------------------------------------
// base64_packet_deframer_unit
// Base64 packet deframer top level: registers, framing core, result queue.
// ----------------------------------------------------------------------------
module base64_packet_deframer_unit #(
  parameter int DEPTH = b64d_pkg::GROUP_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  b64d_in_if.sink          in_ch,
  b64d_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  b64d_pkg::cfg_t   cfg;
  b64d_pkg::group_t push_group;
  logic             push;
  logic             room;

  b64d_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  b64d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .room       (room),
    .in_ch      (in_ch),
    .push       (push),
    .push_group (push_group)
  );

  b64d_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .room       (room),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
